// ===== rtl/pit_pkg.sv =====
`default_nettype none

package pit_pkg;

  localparam int FIELD_BITS = 16;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] point_x;
    logic signed [FIELD_BITS-1:0] point_y;
    logic signed [FIELD_BITS-1:0] point_z;
    logic signed [FIELD_BITS-1:0] corner_a_x;
    logic signed [FIELD_BITS-1:0] corner_a_y;
    logic signed [FIELD_BITS-1:0] corner_a_z;
    logic signed [FIELD_BITS-1:0] corner_b_x;
    logic signed [FIELD_BITS-1:0] corner_b_y;
    logic signed [FIELD_BITS-1:0] corner_b_z;
    logic signed [FIELD_BITS-1:0] corner_c_x;
    logic signed [FIELD_BITS-1:0] corner_c_y;
    logic signed [FIELD_BITS-1:0] corner_c_z;
  } pit_query_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } pit_result_t;

  localparam int NUM_AXES  = 3;
  localparam int NUM_DOTS  = 5;
  localparam int NUM_WIDE  = 6;

  // Dot product slots: e1 = C - A, e2 = B - A, w = P - A.
  localparam int DOT_11 = 0;
  localparam int DOT_12 = 1;
  localparam int DOT_13 = 2;
  localparam int DOT_22 = 3;
  localparam int DOT_23 = 4;

  // Wide product slots.
  localparam int WP_11_22 = 0;
  localparam int WP_12_12 = 1;
  localparam int WP_22_13 = 2;
  localparam int WP_12_23 = 3;
  localparam int WP_11_23 = 4;
  localparam int WP_12_13 = 5;

  // Valid stages ahead of the done register.
  localparam int PIPE_STAGES = 6;

endpackage

`default_nettype wire

// ===== rtl/point_in_triangle_test.sv =====
`default_nettype none

// Channel   Handshake             Payload
// query     start / busy          pit_query_t  (point and three corners)
// result    done (one cycle)      pit_result_t (inside_res, degenerate)
//
// One query is taken in every cycle; busy is always low.
// The result and done are registered together and appear in the same cycle.
// The datapath has seven register stages: differences, axis products, dot
// sums, split partial products, wide products, numerators, and the compare.
// Reset clears the stage valid bits and done only; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever waits.

module point_in_triangle_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pit_pkg::pit_query_t query,
  output logic                busy,
  output logic                done,
  output pit_pkg::pit_result_t result
);
  import pit_pkg::*;

  localparam int EXT_BITS  = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int DOT_BITS  = PROD_BITS + 2;
  localparam int SPLIT     = (DOT_BITS + 1) / 2;
  localparam int HIGH_BITS = DOT_BITS - SPLIT;
  localparam int PART_BITS = 2 * SPLIT + 2;
  localparam int WIDE_BITS = 2 * DOT_BITS;
  localparam int NUM_BITS  = WIDE_BITS + 1;
  localparam int SUM_BITS  = WIDE_BITS + 2;

  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FIELD_BITS-1:0] f);
    logic [EXT_BITS-1:0] raw;
    raw = EXT_BITS'(f);
    return raw[COORD_BITS-1:0];
  endfunction

  logic [PIPE_STAGES-1:0] valid;
  logic                   accept;

  logic signed [COORD_BITS-1:0] pt [NUM_AXES];
  logic signed [COORD_BITS-1:0] ca [NUM_AXES];
  logic signed [COORD_BITS-1:0] cb [NUM_AXES];
  logic signed [COORD_BITS-1:0] cc [NUM_AXES];

  logic signed [DIFF_BITS-1:0] e1 [NUM_AXES];
  logic signed [DIFF_BITS-1:0] e2 [NUM_AXES];
  logic signed [DIFF_BITS-1:0] ew [NUM_AXES];

  logic signed [PROD_BITS-1:0] prod [NUM_DOTS][NUM_AXES];
  logic signed [DOT_BITS-1:0]  dot  [NUM_DOTS];

  logic signed [DOT_BITS-1:0]  op_a [NUM_WIDE];
  logic signed [DOT_BITS-1:0]  op_b [NUM_WIDE];
  logic signed [SPLIT:0]       a_lo [NUM_WIDE];
  logic signed [SPLIT:0]       b_lo [NUM_WIDE];
  logic signed [HIGH_BITS-1:0] a_hi [NUM_WIDE];
  logic signed [HIGH_BITS-1:0] b_hi [NUM_WIDE];

  logic signed [PART_BITS-1:0] part_ll [NUM_WIDE];
  logic signed [PART_BITS-1:0] part_lh [NUM_WIDE];
  logic signed [PART_BITS-1:0] part_hl [NUM_WIDE];
  logic signed [PART_BITS-1:0] part_hh [NUM_WIDE];

  logic signed [WIDE_BITS-1:0] wide [NUM_WIDE];

  logic signed [NUM_BITS-1:0]  den;
  logic signed [NUM_BITS-1:0]  num_u;
  logic signed [NUM_BITS-1:0]  num_v;
  logic signed [SUM_BITS-1:0]  num_sum;
  logic                        degen;
  logic                        in_tri;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    pt[0] = to_coord(query.point_x);
    pt[1] = to_coord(query.point_y);
    pt[2] = to_coord(query.point_z);
    ca[0] = to_coord(query.corner_a_x);
    ca[1] = to_coord(query.corner_a_y);
    ca[2] = to_coord(query.corner_a_z);
    cb[0] = to_coord(query.corner_b_x);
    cb[1] = to_coord(query.corner_b_y);
    cb[2] = to_coord(query.corner_b_z);
    cc[0] = to_coord(query.corner_c_x);
    cc[1] = to_coord(query.corner_c_y);
    cc[2] = to_coord(query.corner_c_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[PIPE_STAGES-2:0], accept};
      done  <= valid[PIPE_STAGES-1];
    end
  end

  // Stage 1: edge vectors and offset from corner A.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      e1[i] <= DIFF_BITS'(cc[i]) - DIFF_BITS'(ca[i]);
      e2[i] <= DIFF_BITS'(cb[i]) - DIFF_BITS'(ca[i]);
      ew[i] <= DIFF_BITS'(pt[i]) - DIFF_BITS'(ca[i]);
    end
  end

  // Stage 2: per-axis products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      prod[DOT_11][i] <= e1[i] * e1[i];
      prod[DOT_12][i] <= e1[i] * e2[i];
      prod[DOT_13][i] <= e1[i] * ew[i];
      prod[DOT_22][i] <= e2[i] * e2[i];
      prod[DOT_23][i] <= e2[i] * ew[i];
    end
  end

  // Stage 3: dot product sums.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_DOTS; k++) begin
      dot[k] <= DOT_BITS'(prod[k][0]) + DOT_BITS'(prod[k][1]) + DOT_BITS'(prod[k][2]);
    end
  end

  // Stage 4: each wide product is split into four half-width partial products.
  always_comb begin
    op_a[WP_11_22] = dot[DOT_11];
    op_b[WP_11_22] = dot[DOT_22];
    op_a[WP_12_12] = dot[DOT_12];
    op_b[WP_12_12] = dot[DOT_12];
    op_a[WP_22_13] = dot[DOT_22];
    op_b[WP_22_13] = dot[DOT_13];
    op_a[WP_12_23] = dot[DOT_12];
    op_b[WP_12_23] = dot[DOT_23];
    op_a[WP_11_23] = dot[DOT_11];
    op_b[WP_11_23] = dot[DOT_23];
    op_a[WP_12_13] = dot[DOT_12];
    op_b[WP_12_13] = dot[DOT_13];
    for (int j = 0; j < NUM_WIDE; j++) begin
      a_lo[j] = {1'b0, op_a[j][SPLIT-1:0]};
      b_lo[j] = {1'b0, op_b[j][SPLIT-1:0]};
      a_hi[j] = op_a[j][DOT_BITS-1:SPLIT];
      b_hi[j] = op_b[j][DOT_BITS-1:SPLIT];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_WIDE; j++) begin
      part_ll[j] <= a_lo[j] * b_lo[j];
      part_lh[j] <= a_lo[j] * b_hi[j];
      part_hl[j] <= a_hi[j] * b_lo[j];
      part_hh[j] <= a_hi[j] * b_hi[j];
    end
  end

  // Stage 5: recombine the partial products.
  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_WIDE; j++) begin
      wide[j] <= (WIDE_BITS'(part_hh[j]) <<< (2 * SPLIT))
               + ((WIDE_BITS'(part_hl[j]) + WIDE_BITS'(part_lh[j])) <<< SPLIT)
               + WIDE_BITS'(part_ll[j]);
    end
  end

  // Stage 6: denominator and the two barycentric numerators.
  always_ff @(posedge clk) begin
    den   <= NUM_BITS'(wide[WP_11_22]) - NUM_BITS'(wide[WP_12_12]);
    num_u <= NUM_BITS'(wide[WP_22_13]) - NUM_BITS'(wide[WP_12_23]);
    num_v <= NUM_BITS'(wide[WP_11_23]) - NUM_BITS'(wide[WP_12_13]);
  end

  // Stage 7: exact inside test.
  always_comb begin
    degen   = (den == '0);
    num_sum = SUM_BITS'(num_u) + SUM_BITS'(num_v);
    in_tri  = !degen && !num_u[NUM_BITS-1] && !num_v[NUM_BITS-1]
              && (num_sum < SUM_BITS'(den));
  end

  always_ff @(posedge clk) begin
    result.inside_res <= in_tri;
    result.degenerate <= degen;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(PIPE_STAGES + 1) done)
    else $error("accepted beat did not produce a result");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##(PIPE_STAGES + 1) !done)
    else $error("result strobe without an accepted beat");

  a_den_sign : assert property (@(posedge clk) disable iff (rst)
    valid[PIPE_STAGES-1] |-> !den[NUM_BITS-1])
    else $error("negative barycentric denominator");

  a_degen_outside : assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |-> !result.inside_res)
    else $error("degenerate triangle reported as inside");

endmodule

`default_nettype wire
